>>> rtl/bole_pkg.sv
package bole_pkg;

  // List size and the widths that follow from it.
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_W    = 8;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request kinds.
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_INSERT_AT  = 3'd4;
  localparam logic [2:0] KIND_DELETE_AT  = 3'd5;

  // Result status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_UNDER  = 2'd1;
  localparam logic [1:0] STAT_BOUNDS = 2'd2;
  localparam logic [1:0] STAT_FULL   = 2'd3;

  // Datapath operations.
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_PUT  = 2'd1;
  localparam logic [1:0] OP_TAKE = 2'd2;

  typedef struct packed {
    logic [2:0]        kind;
    logic [POS_W-1:0]  position;
    logic signed [31:0] value;
  } bole_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } bole_rsp_t;

  // Command from the controller to the cell chain.
  typedef struct packed {
    logic [1:0]         op;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] value;
  } bole_cmd_t;

  // Status from the cell chain back to the controller.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             full;
  } bole_stat_t;

endpackage

>>> rtl/bole_datapath.sv
module bole_datapath
  import bole_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  bole_cmd_t          cmd,
  output bole_stat_t         stat,
  output logic [CNT_W-1:0]   count,
  output logic signed [31:0] front_value,
  output logic signed [31:0] back_value
);

  logic signed [31:0] cells_r [CAPACITY];
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [CNT_W-1:0]   last;

  // Each cell holds, takes the new value, or shifts from a neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.op == OP_PUT) begin
        if (cmd.idx == IDX_W'(i)) begin
          cells_r[i] <= cmd.value;
        end else if (cmd.idx < IDX_W'(i)) begin
          if (i > 0) begin
            cells_r[i] <= cells_r[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (cmd.op == OP_TAKE) begin
        if (cmd.idx <= IDX_W'(i) && i < CAPACITY - 1) begin
          cells_r[i] <= cells_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Entry count follows the operation.
  always_comb begin
    count_nxt = count_r;
    case (cmd.op)
      OP_PUT:  count_nxt = count_r + CNT_W'(1);
      OP_TAKE: count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Status toward the controller and the ends of the list.
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r >= CNT_W'(CAPACITY));
  assign last       = count_r - CNT_W'(1);
  assign count      = count_r;
  assign front_value = stat.empty ? 32'sd0 : cells_r[0];
  assign back_value  = stat.empty ? 32'sd0 : cells_r[last[IDX_W-1:0]];

endmodule

>>> rtl/bole_ctrl.sv
module bole_ctrl
  import bole_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  bole_req_t  req,
  input  bole_stat_t stat,
  output logic       busy,
  output bole_cmd_t  cmd,
  output logic       result_strobe,
  output logic [1:0] result_status
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_RESULT = 1'b1;

  logic       state_r, state_nxt;
  logic       busy_r;
  logic [1:0] status_r, status_nxt;
  logic       accept;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CNT_W-1:0] cnt_last;

  assign accept   = start && !busy_r;
  assign pos_ext  = CMP_W'(req.position);
  assign cnt_ext  = CMP_W'(stat.count);
  assign cnt_last = stat.count - CNT_W'(1);

  // Decode the request against the current count.
  always_comb begin
    cmd.op     = OP_HOLD;
    cmd.idx    = '0;
    cmd.value  = req.value;
    status_nxt = STAT_OK;
    case (req.kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (stat.full) begin
          status_nxt = STAT_FULL;
        end else begin
          cmd.op  = OP_PUT;
          cmd.idx = (req.kind == KIND_PUSH_FRONT) ? '0 : stat.count[IDX_W-1:0];
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (stat.empty) begin
          status_nxt = STAT_UNDER;
        end else begin
          cmd.op  = OP_TAKE;
          cmd.idx = (req.kind == KIND_POP_FRONT) ? '0 : cnt_last[IDX_W-1:0];
        end
      end
      KIND_INSERT_AT: begin
        if (pos_ext > cnt_ext) begin
          status_nxt = STAT_BOUNDS;
        end else if (stat.full) begin
          status_nxt = STAT_FULL;
        end else begin
          cmd.op  = OP_PUT;
          cmd.idx = pos_ext[IDX_W-1:0];
        end
      end
      KIND_DELETE_AT: begin
        if (stat.empty) begin
          status_nxt = STAT_UNDER;
        end else if (pos_ext >= cnt_ext) begin
          status_nxt = STAT_BOUNDS;
        end else begin
          cmd.op  = OP_TAKE;
          cmd.idx = pos_ext[IDX_W-1:0];
        end
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
    if (!accept) begin
      cmd.op = OP_HOLD;
    end
  end

  // A result follows every accepted request in the next cycle.
  always_comb begin
    state_nxt = accept ? S_RESULT : S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= 1'b0;
    end
  end

  // Status register for the pending result.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  assign busy          = busy_r;
  assign result_strobe = (state_r == S_RESULT);
  assign result_status = status_r;

endmodule

>>> rtl/bounded_ordered_list_engine.sv
// Bounded ordered list engine.
// Holds an ordered list of up to CAPACITY signed 32-bit values, front first,
// in a chain of registered cells. A request is taken at a rising edge where
// start is high and busy is low; in_req carries the kind (push front/back,
// pop front/back, insert at, delete at), a position and a value.
// Insert and delete shift every later cell by one place in the same edge.
// The result appears on out_rsp for exactly one cycle, marked by out_strobe,
// in the cycle right after the request is taken.
// A new request may be taken in every cycle, including the cycle in which
// the previous result is shown, so throughput is one request per cycle; the
// single cell-chain update per edge sets that figure.
// The result carries the status, the new entry count and the front and back
// values (zero when the list is empty). Failed requests leave the list as is.
// Synchronous reset empties the list; busy is high during reset and for the
// first cycle after reset is released. The receiver cannot stall: each
// result must be taken in the cycle in which it is shown.
module bounded_ordered_list_engine
  import bole_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  bole_req_t in_req,
  output logic      out_strobe,
  output bole_rsp_t out_rsp
);

  bole_cmd_t          cmd;
  bole_stat_t         stat;
  logic [CNT_W-1:0]   count;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic [1:0]         result_status;

  bole_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .req           (in_req),
    .stat          (stat),
    .busy          (busy),
    .cmd           (cmd),
    .result_strobe (out_strobe),
    .result_status (result_status)
  );

  bole_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .count       (count),
    .front_value (front_value),
    .back_value  (back_value)
  );

  // Assemble the result.
  assign out_rsp.status      = result_status;
  assign out_rsp.entry_count = 5'(count);
  assign out_rsp.front_value = front_value;
  assign out_rsp.back_value  = back_value;

  // A result is only shown after a request was taken.
  a_strobe_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy))
    else $error("result without a request");

  // The count never passes the capacity.
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A failed request leaves the count unchanged.
  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_rsp.status != STAT_OK && $past(rst_n)) |-> $stable(count))
    else $error("failed request changed the list");

  // An empty list shows zero at both ends.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (count == '0) |-> (front_value == 32'sd0 && back_value == 32'sd0))
    else $error("empty list shows nonzero ends");

endmodule
